>>> sv/rmth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_pkg: shared definitions for the running median block
// default sizes and the control word that drives a chain of sorted cells
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int DEF_HALF_DEPTH   = 512;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // chain operation: insert a value, or drop the top and insert
  typedef struct packed {
    logic ins;
    logic rep;
  } chain_ctl_t;

endpackage
`default_nettype wire

>>> sv/rmth_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_cell: one slot of a sorted chain
// holds one sample and moves it to or from its neighbors on insert / replace
// ----------------------------------------------------------------------------
module rmth_cell #(
  parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_WIDTH,
  parameter int COUNT_WIDTH  = 10,
  parameter int INDEX        = 0,
  parameter bit IS_MAX       = 1'b1
) (
  input  wire                           clk,
  input  rmth_pkg::chain_ctl_t          ctl,
  input  wire        [COUNT_WIDTH-1:0]  count,
  input  wire signed [SAMPLE_WIDTH-1:0] value,
  input  wire signed [SAMPLE_WIDTH-1:0] prev_val,
  input  wire                           prev_c,
  input  wire signed [SAMPLE_WIDTH-1:0] next_val,
  input  wire                           next_c,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                          c
);

  localparam bit IS_FIRST = (INDEX == 0);

  logic signed [SAMPLE_WIDTH-1:0] val_next;
  logic                           outranks;

  // held value sits strictly ahead of the broadcast value
  assign outranks = IS_MAX ? (val > value) : (val < value);
  assign c        = (count > COUNT_WIDTH'(INDEX)) && outranks;

  always_comb begin
    val_next = val;
    if (ctl.ins) begin
      // keep, take the new value, or take the left neighbor
      if (c) begin
        val_next = val;
      end else if (prev_c) begin
        val_next = value;
      end else begin
        val_next = prev_val;
      end
    end else if (ctl.rep) begin
      // top leaves: pull from the right, take the new value, or keep
      if (next_c) begin
        val_next = next_val;
      end else if (c || IS_FIRST) begin
        val_next = value;
      end else begin
        val_next = val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

>>> sv/rmth_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_chain: row of sorted cells forming one half of the samples
// cell 0 holds the top (largest for the lower half, smallest for the upper)
// ----------------------------------------------------------------------------
module rmth_chain #(
  parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_WIDTH,
  parameter int HALF_DEPTH   = rmth_pkg::DEF_HALF_DEPTH,
  parameter int COUNT_WIDTH  = $clog2(HALF_DEPTH + 1),
  parameter bit IS_MAX       = 1'b1
) (
  input  wire                           clk,
  input  rmth_pkg::chain_ctl_t          ctl,
  input  wire        [COUNT_WIDTH-1:0]  count,
  input  wire signed [SAMPLE_WIDTH-1:0] value,
  output logic signed [SAMPLE_WIDTH-1:0] top
);

  logic signed [SAMPLE_WIDTH-1:0] cell_val [HALF_DEPTH];
  logic                           cell_c   [HALF_DEPTH];

  for (genvar i = 0; i < HALF_DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] pv;
    logic                           pc;
    logic signed [SAMPLE_WIDTH-1:0] nv;
    logic                           nc;

    if (i == 0) begin : g_head
      assign pv = value;
      assign pc = 1'b1;
    end else begin : g_body
      assign pv = cell_val[i-1];
      assign pc = cell_c[i-1];
    end

    if (i == HALF_DEPTH - 1) begin : g_tail
      assign nv = value;
      assign nc = 1'b0;
    end else begin : g_link
      assign nv = cell_val[i+1];
      assign nc = cell_c[i+1];
    end

    rmth_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .INDEX        (i),
      .IS_MAX       (IS_MAX)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .value    (value),
      .prev_val (pv),
      .prev_c   (pc),
      .next_val (nv),
      .next_c   (nc),
      .val      (cell_val[i]),
      .c        (cell_c[i])
    );
  end

  assign top = cell_val[0];

endmodule
`default_nettype wire

>>> sv/running_median_two_heaps.sv
`default_nettype none
// sequence: each accepted item runs the insert, check, exchange and finish steps on the
//   two cell chains; the median is registered in the finish step, which waits while
//   out_stall holds the output; no new item is taken until the sequencer is idle again
// reset: clears both fill counts, the sequencer and the output valid
// the cells themselves are not cleared, entries past the fill counts are never used
// ----------------------------------------------------------------------------
// running_median_two_heaps: lower median of all samples held so far
// two sorted cell chains hold the lower and upper halves of the samples
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
  parameter int HALF_DEPTH   = rmth_pkg::DEF_HALF_DEPTH,
  parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire signed [SAMPLE_WIDTH-1:0]           sample,
  input  wire                                     restart,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]          median,
  output logic [$clog2(2*HALF_DEPTH+1)-1:0]       count_held,
  output logic                                    overflow
);

  localparam int CW = $clog2(HALF_DEPTH + 1);
  localparam int TW = $clog2(2 * HALF_DEPTH + 1);

  // item sequencer
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INSERT = 5'b00010,
    S_CHECK  = 5'b00100,
    S_SWAP   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  // captured item
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           restart_q;

  // fill counts of the two halves
  logic [CW-1:0] lower_count, lower_count_next;
  logic [CW-1:0] upper_count, upper_count_next;

  logic                           ovf_q;
  logic                           swap_q;
  logic signed [SAMPLE_WIDTH-1:0] lo_top_q;
  logic signed [SAMPLE_WIDTH-1:0] up_top_q;

  // chain interface
  rmth_pkg::chain_ctl_t           lo_ctl, up_ctl;
  logic [CW-1:0]                  lo_cnt_in, up_cnt_in;
  logic signed [SAMPLE_WIDTH-1:0] lo_val_in, up_val_in;
  logic signed [SAMPLE_WIDTH-1:0] lo_top, up_top;

  // insert step decode
  logic [CW-1:0] lc_eff, uc_eff;
  logic          full;
  logic          to_lower;

  logic in_accept;
  logic out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // restart empties both halves before this item goes in
  assign lc_eff   = restart_q ? '0 : lower_count;
  assign uc_eff   = restart_q ? '0 : upper_count;
  assign full     = (lc_eff == CW'(HALF_DEPTH)) && (uc_eff == CW'(HALF_DEPTH));
  // equal halves: lower takes the sample, otherwise upper does
  assign to_lower = (lc_eff == uc_eff);

  always_comb begin
    lo_ctl    = '0;
    up_ctl    = '0;
    lo_cnt_in = lower_count;
    up_cnt_in = upper_count;
    lo_val_in = up_top_q;
    up_val_in = lo_top_q;
    unique case (state)
      S_INSERT: begin
        lo_ctl.ins = !full && to_lower;
        up_ctl.ins = !full && !to_lower;
        lo_cnt_in  = lc_eff;
        up_cnt_in  = uc_eff;
        lo_val_in  = sample_q;
        up_val_in  = sample_q;
      end
      S_SWAP: begin
        // exchange tops: each half drops its top and takes the other's
        lo_ctl.rep = swap_q;
        up_ctl.rep = swap_q;
      end
      default: begin
      end
    endcase
  end

  rmth_chain #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .HALF_DEPTH   (HALF_DEPTH),
    .COUNT_WIDTH  (CW),
    .IS_MAX       (1'b1)
  ) u_lower (
    .clk   (clk),
    .ctl   (lo_ctl),
    .count (lo_cnt_in),
    .value (lo_val_in),
    .top   (lo_top)
  );

  rmth_chain #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .HALF_DEPTH   (HALF_DEPTH),
    .COUNT_WIDTH  (CW),
    .IS_MAX       (1'b0)
  ) u_upper (
    .clk   (clk),
    .ctl   (up_ctl),
    .count (up_cnt_in),
    .value (up_val_in),
    .top   (up_top)
  );

  always_comb begin
    state_next       = state;
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        lower_count_next = lc_eff + CW'(lo_ctl.ins);
        upper_count_next = uc_eff + CW'(up_ctl.ins);
        state_next       = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_SWAP;
      end
      S_SWAP: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lower_count <= '0;
      upper_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q  <= sample;
      restart_q <= restart;
    end
    if (state == S_INSERT) begin
      ovf_q <= full;
    end
    if (state == S_CHECK) begin
      // exchange only when the lower top is strictly above the upper top
      swap_q   <= (lower_count != '0) && (upper_count != '0) && (lo_top > up_top);
      lo_top_q <= lo_top;
      up_top_q <= up_top;
    end
    if (state == S_FINISH && out_free) begin
      median     <= lo_top;
      count_held <= TW'(lower_count) + TW'(upper_count);
      overflow   <= ovf_q;
    end
  end

`ifndef NO_ASSERTIONS
  // halves stay balanced, lower holds the extra sample
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (lower_count == upper_count) || (lower_count == upper_count + CW'(1)))
    else $error("halves out of balance");

  // fill counts never pass the chain length
  a_bound: assert property (@(posedge clk) disable iff (rst)
    (lower_count <= CW'(HALF_DEPTH)) && (upper_count <= CW'(HALF_DEPTH)))
    else $error("fill count past chain length");

  // after the exchange step the halves are ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && lower_count != '0 && upper_count != '0) |-> (lo_top <= up_top))
    else $error("lower top above upper top");

  // a dropped sample is only reported with both halves full
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (count_held == TW'(2 * HALF_DEPTH)))
    else $error("overflow with room left");

  // an accepted item starts the insert step next cycle
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_INSERT))
    else $error("insert step missed");
`endif

endmodule
`default_nettype wire
